/* design/smsc_pkg.sv */
// ----------------------------------------------------------------------------
// smsc_pkg: shared constants for the sliding-mode speed controller
// Field widths, fixed datapath widths and register indexes.
// ----------------------------------------------------------------------------
package smsc_pkg;

   // default fixed-point format, Q16.16
   localparam int FRAC_BITS_DEF = 16;

   // port widths
   localparam int DATA_W = 32;
   localparam int ADDR_W = 4;
   localparam int GAIN_W = 31;

   // integral bound, in whole units, and the integer bits it needs
   localparam int INTEG_LIMIT = 1600;
   localparam int INT_HEAD_W  = 11;

   // lambda * |integral| >> FRAC_BITS stays below 2^(GAIN_W + INT_HEAD_W)
   localparam int P1_W   = GAIN_W + INT_HEAD_W;
   // negated surface, signed, and its magnitude
   localparam int S_W    = P1_W + 2;
   localparam int SMAG_W = P1_W + 1;
   // |s| + delta
   localparam int DEN_W  = SMAG_W + 1;
   // |s| * eta, full product
   localparam int PB_W   = SMAG_W + GAIN_W;
   // |s| * eta >> FRAC_BITS, saturated
   localparam int B_W    = GAIN_W + 2;
   // drive magnitude before the output clamp
   localparam int M_W    = B_W + 1;

   // serial divide-by-5 and serial multiply over a gain: GAIN_W steps
   localparam int ETA_CNT_W   = 5;
   localparam int ETA_DIVISOR = 5;

   // register indexes
   localparam logic [1:0] REG_OUTPUT_LIMIT   = 2'd0;
   localparam logic [1:0] REG_SURFACE_GAIN   = 2'd1;
   localparam logic [1:0] REG_SWITCHING_GAIN = 2'd2;
   localparam logic [1:0] REG_BOUNDARY_WIDTH = 2'd3;

endpackage

/* design/sliding_mode_speed_controller_core.sv */
// ----------------------------------------------------------------------------
// sliding_mode_speed_controller_core: integral sliding-mode speed controller
// Error integral, sliding surface, boundary-layer sign and saturated drive,
// built on bit-serial multipliers and a restoring divider.
// ----------------------------------------------------------------------------
// Sequence: accept, integral update, lambda*|integral| on unit A, surface,
//   divider, then k * smoothed sign on unit A, with the 31-step surface
//   multiply on unit B overlapping the last two. Format: Q16.16 by default.
// Flow: a request is taken only in idle; a full output slot holds ST_OUT.
// Reset: synchronous; registers return to defaults, integral cleared, and
//   req_ready stays low while 0.8*lambda is formed by a serial divide-by-5
//   (again after every surface_gain write).
// ----------------------------------------------------------------------------
module sliding_mode_speed_controller_core #(
   parameter int FRAC_BITS = smsc_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input transactions
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [smsc_pkg::DATA_W-1:0]  req_target_speed,
   input  logic signed [smsc_pkg::DATA_W-1:0]  req_measured_speed,
   // result transactions
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [smsc_pkg::DATA_W-1:0]  rsp_drive,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [smsc_pkg::ADDR_W-1:0]         paddr,
   input  logic [smsc_pkg::DATA_W-1:0]         pwdata,
   output logic [smsc_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   // |integral| width and signed integral width
   localparam int QA_W  = FRAC_BITS + smsc_pkg::INT_HEAD_W;
   localparam int IW    = QA_W + 1;
   localparam int SUM_W = ((IW > smsc_pkg::DATA_W + 1) ? IW : smsc_pkg::DATA_W + 1) + 1;
   localparam int CNT_W = $clog2(QA_W + 1);

   localparam logic [smsc_pkg::GAIN_W-1:0] Q_ONE =
      smsc_pkg::GAIN_W'(1) << FRAC_BITS;
   // 0.01 in the working format, rounded
   localparam logic [smsc_pkg::GAIN_W-1:0] DELTA_DEF =
      smsc_pkg::GAIN_W'(((1 << FRAC_BITS) + 50) / 100);
   localparam logic signed [SUM_W-1:0] INTEG_MAX =
      SUM_W'(smsc_pkg::INTEG_LIMIT) << FRAC_BITS;
   localparam logic signed [SUM_W-1:0] INTEG_MIN = -INTEG_MAX;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_INTEG = 4'd1;
   localparam logic [3:0] ST_LOAD1 = 4'd2;
   localparam logic [3:0] ST_MUL1  = 4'd3;
   localparam logic [3:0] ST_SURF  = 4'd4;
   localparam logic [3:0] ST_PREP  = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_MUL2  = 4'd7;
   localparam logic [3:0] ST_DRIVE = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   // ------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------
   logic [smsc_pkg::GAIN_W-1:0] lim_ff;
   logic [smsc_pkg::GAIN_W-1:0] sg_ff;
   logic [smsc_pkg::GAIN_W-1:0] kg_ff;
   logic [smsc_pkg::GAIN_W-1:0] bw_ff;
   logic                        csr_wr;
   logic [1:0]                  csr_idx;
   logic [smsc_pkg::GAIN_W-1:0] lam_eff;
   logic [smsc_pkg::GAIN_W-1:0] kg_eff;
   logic [smsc_pkg::GAIN_W-1:0] dl_eff;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[smsc_pkg::ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= '0;
         sg_ff  <= Q_ONE;
         kg_ff  <= Q_ONE;
         bw_ff  <= DELTA_DEF;
      end else if (csr_wr) begin
         case (csr_idx)
            smsc_pkg::REG_OUTPUT_LIMIT:   lim_ff <= pwdata[smsc_pkg::GAIN_W-1:0];
            smsc_pkg::REG_SURFACE_GAIN:   sg_ff  <= pwdata[smsc_pkg::GAIN_W-1:0];
            smsc_pkg::REG_SWITCHING_GAIN: kg_ff  <= pwdata[smsc_pkg::GAIN_W-1:0];
            smsc_pkg::REG_BOUNDARY_WIDTH: bw_ff  <= pwdata[smsc_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         smsc_pkg::REG_OUTPUT_LIMIT:   prdata = {1'b0, lim_ff};
         smsc_pkg::REG_SURFACE_GAIN:   prdata = {1'b0, sg_ff};
         smsc_pkg::REG_SWITCHING_GAIN: prdata = {1'b0, kg_ff};
         smsc_pkg::REG_BOUNDARY_WIDTH: prdata = {1'b0, bw_ff};
         default:                      prdata = '0;
      endcase
   end

   // zero gains fall back to 1.0, zero width to 0.01
   assign lam_eff = (sg_ff == '0) ? Q_ONE : sg_ff;
   assign kg_eff  = (kg_ff == '0) ? Q_ONE : kg_ff;
   assign dl_eff  = (bw_ff == '0) ? DELTA_DEF : bw_ff;

   // ------------------------------------------------------------------
   // eta = floor(4*lambda/5): serial divide of lambda by 5, MSB first.
   // 4*q + floor(4*r/5) where floor(4*r/5) is r-1 for r > 0.
   // ------------------------------------------------------------------
   logic                           ed_pend_ff;
   logic [smsc_pkg::ETA_CNT_W-1:0] ed_cnt_ff;
   logic [smsc_pkg::GAIN_W-1:0]    ed_sh_ff;
   logic [2:0]                     ed_rem_ff;
   logic [3:0]                     ed_trial;
   logic                           ed_ge;
   logic [2:0]                     ed_rem_step;
   logic [1:0]                     ed_adj;
   logic [smsc_pkg::GAIN_W-1:0]    eta;
   logic                           eta_ready;

   assign ed_trial    = {ed_rem_ff, ed_sh_ff[smsc_pkg::GAIN_W-1]};
   assign ed_ge       = ed_trial >= 4'(smsc_pkg::ETA_DIVISOR);
   assign ed_rem_step = ed_ge ? 3'(ed_trial - 4'(smsc_pkg::ETA_DIVISOR)) : ed_trial[2:0];
   assign ed_adj      = (ed_rem_ff == '0) ? 2'd0 : 2'(ed_rem_ff - 3'd1);
   assign eta         = {ed_sh_ff[smsc_pkg::GAIN_W-3:0], ed_adj};
   assign eta_ready   = !ed_pend_ff && (ed_cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         ed_pend_ff <= 1'b1;
         ed_cnt_ff  <= '0;
      end else begin
         if (ed_pend_ff) begin
            ed_cnt_ff <= smsc_pkg::ETA_CNT_W'(smsc_pkg::GAIN_W);
         end else if (ed_cnt_ff != '0) begin
            ed_cnt_ff <= ed_cnt_ff - smsc_pkg::ETA_CNT_W'(1);
         end
         ed_pend_ff <= csr_wr && (csr_idx == smsc_pkg::REG_SURFACE_GAIN);
      end
   end

   always_ff @(posedge clock) begin
      if (ed_pend_ff) begin
         ed_sh_ff  <= lam_eff;
         ed_rem_ff <= '0;
      end else if (ed_cnt_ff != '0) begin
         ed_sh_ff  <= {ed_sh_ff[smsc_pkg::GAIN_W-2:0], ed_ge};
         ed_rem_ff <= ed_rem_step;
      end
   end

   // ------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------
   logic [3:0]                           state_ff,    state_in;
   logic [CNT_W-1:0]                     cnt_ff,      cnt_in;
   logic signed [IW-1:0]                 integ_ff,    integ_in;
   logic signed [smsc_pkg::DATA_W:0]     err_ff,      err_in;
   // unit A: serial multiplier, gain times |integral| or smoothed sign
   logic [smsc_pkg::GAIN_W-1:0]          ma_acc_ff,   ma_acc_in;
   logic [smsc_pkg::GAIN_W-1:0]          ma_mc_ff,    ma_mc_in;
   logic [QA_W-1:0]                      ma_q_ff,     ma_q_in;
   // negated surface and sign of s
   logic signed [smsc_pkg::S_W-1:0]      x_ff,        x_in;
   logic                                 s_neg_ff,    s_neg_in;
   // restoring divider |s| / (|s| + delta)
   logic [smsc_pkg::DEN_W-1:0]           dv_rem_ff,   dv_rem_in;
   logic [smsc_pkg::DEN_W-1:0]           dv_den_ff,   dv_den_in;
   logic [FRAC_BITS-1:0]                 dv_q_ff,     dv_q_in;
   // unit B: serial multiplier, |s| times eta
   logic [smsc_pkg::SMAG_W-1:0]          mb_acc_ff,   mb_acc_in;
   logic [smsc_pkg::SMAG_W-1:0]          mb_mc_ff,    mb_mc_in;
   logic [smsc_pkg::GAIN_W-1:0]          mb_q_ff,     mb_q_in;
   logic [smsc_pkg::ETA_CNT_W-1:0]       mb_cnt_ff,   mb_cnt_in;
   // drive magnitude and output slot
   logic [smsc_pkg::M_W-1:0]             m_ff,        m_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [smsc_pkg::DATA_W-1:0]   rsp_drive_ff, rsp_drive_in;

   // ------------------------------------------------------------------
   // Step logic
   // ------------------------------------------------------------------
   logic signed [SUM_W-1:0]              integ_sum;
   logic signed [SUM_W-1:0]              integ_clamp;
   logic [QA_W-1:0]                      integ_mag;
   logic [smsc_pkg::GAIN_W:0]            ma_sum;
   logic [smsc_pkg::SMAG_W:0]            mb_sum;
   logic [smsc_pkg::P1_W-1:0]            p1;
   logic signed [smsc_pkg::S_W-1:0]      p1_ext;
   logic signed [smsc_pkg::S_W-1:0]      err_ext;
   logic [smsc_pkg::SMAG_W-1:0]          s_mag;
   logic [smsc_pkg::DEN_W-1:0]           den;
   logic [smsc_pkg::DEN_W:0]             dv_shift;
   logic [smsc_pkg::DEN_W:0]             dv_diff;
   logic                                 dv_ge;
   logic [smsc_pkg::DEN_W-1:0]           dv_rem_step;
   logic [FRAC_BITS-1:0]                 dv_q_step;
   logic [smsc_pkg::PB_W-1:0]            prod_b;
   logic                                 b_ovf;
   logic [smsc_pkg::B_W-1:0]             b_sat;
   logic [smsc_pkg::GAIN_W-1:0]          m_lim;
   logic [smsc_pkg::DATA_W-1:0]          drive_mag;

   // integral update with clamp to +/-1600
   assign integ_sum   = SUM_W'(integ_ff) + SUM_W'(err_ff);
   assign integ_clamp = (integ_sum > INTEG_MAX) ? INTEG_MAX :
                        (integ_sum < INTEG_MIN) ? INTEG_MIN : integ_sum;
   assign integ_mag   = integ_ff[IW-1] ? QA_W'(-integ_ff) : QA_W'(integ_ff);

   // one multiplier bit per cycle; low product bits shift into the q register
   assign ma_sum = {1'b0, ma_acc_ff} + (ma_q_ff[0] ? {1'b0, ma_mc_ff} : '0);
   assign mb_sum = {1'b0, mb_acc_ff} + (mb_q_ff[0] ? {1'b0, mb_mc_ff} : '0);

   // lambda*|integral| >> FRAC_BITS
   assign p1      = {ma_acc_ff, ma_q_ff[QA_W-1:FRAC_BITS]};
   assign p1_ext  = {2'b00, p1};
   assign err_ext = smsc_pkg::S_W'(err_ff);

   // x = -s; |s| and |s| + delta from x directly
   assign s_mag = x_ff[smsc_pkg::S_W-1] ? smsc_pkg::SMAG_W'(-x_ff)
                                         : smsc_pkg::SMAG_W'(x_ff);
   assign den   = x_ff[smsc_pkg::S_W-1]
                ? (smsc_pkg::DEN_W'(dl_eff) - smsc_pkg::DEN_W'(x_ff))
                : (smsc_pkg::DEN_W'(x_ff) + smsc_pkg::DEN_W'(dl_eff));

   // one quotient bit per cycle
   assign dv_shift    = {dv_rem_ff, 1'b0};
   assign dv_diff     = dv_shift - {1'b0, dv_den_ff};
   assign dv_ge       = dv_shift >= {1'b0, dv_den_ff};
   assign dv_rem_step = dv_ge ? dv_diff[smsc_pkg::DEN_W-1:0]
                              : dv_shift[smsc_pkg::DEN_W-1:0];
   assign dv_q_step   = {dv_q_ff[FRAC_BITS-2:0], dv_ge};

   // |s|*eta >> FRAC_BITS; anything past B_W bits is beyond any limit
   assign prod_b = {mb_acc_ff, mb_q_ff};
   assign b_ovf  = |prod_b[smsc_pkg::PB_W-1:FRAC_BITS+smsc_pkg::B_W];
   assign b_sat  = b_ovf ? '1 : prod_b[FRAC_BITS+smsc_pkg::B_W-1:FRAC_BITS];

   // output clamp; both drive terms carry the sign of -s
   assign m_lim     = (m_ff > smsc_pkg::M_W'(lim_ff)) ? lim_ff
                                                      : m_ff[smsc_pkg::GAIN_W-1:0];
   assign drive_mag = {1'b0, m_lim};

   assign req_ready = (state_ff == ST_IDLE) && eta_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      integ_in     = integ_ff;
      err_in       = err_ff;
      ma_acc_in    = ma_acc_ff;
      ma_mc_in     = ma_mc_ff;
      ma_q_in      = ma_q_ff;
      x_in         = x_ff;
      s_neg_in     = s_neg_ff;
      dv_rem_in    = dv_rem_ff;
      dv_den_in    = dv_den_ff;
      dv_q_in      = dv_q_ff;
      mb_acc_in    = mb_acc_ff;
      mb_mc_in     = mb_mc_ff;
      mb_q_in      = mb_q_ff;
      mb_cnt_in    = mb_cnt_ff;
      m_in         = m_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_drive_in = rsp_drive_ff;

      // unit B runs on its own count, overlapping the divider and unit A
      if (mb_cnt_ff != '0) begin
         mb_acc_in = mb_sum[smsc_pkg::SMAG_W:1];
         mb_q_in   = {mb_sum[0], mb_q_ff[smsc_pkg::GAIN_W-1:1]};
         mb_cnt_in = mb_cnt_ff - smsc_pkg::ETA_CNT_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               err_in   = (smsc_pkg::DATA_W + 1)'(req_target_speed)
                        - (smsc_pkg::DATA_W + 1)'(req_measured_speed);
               state_in = ST_INTEG;
            end
         end
         ST_INTEG: begin
            integ_in = IW'(integ_clamp);
            state_in = ST_LOAD1;
         end
         ST_LOAD1: begin
            ma_acc_in = '0;
            ma_mc_in  = lam_eff;
            ma_q_in   = integ_mag;
            cnt_in    = '0;
            state_in  = ST_MUL1;
         end
         ST_MUL1: begin
            ma_acc_in = ma_sum[smsc_pkg::GAIN_W:1];
            ma_q_in   = {ma_sum[0], ma_q_ff[QA_W-1:1]};
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(QA_W - 1)) begin
               state_in = ST_SURF;
            end
         end
         ST_SURF: begin
            // x = err + sign(integral) * p1
            x_in     = integ_ff[IW-1] ? (err_ext - p1_ext) : (err_ext + p1_ext);
            state_in = ST_PREP;
         end
         ST_PREP: begin
            s_neg_in  = !x_ff[smsc_pkg::S_W-1] && (x_ff != '0);
            dv_rem_in = {1'b0, s_mag};
            dv_den_in = den;
            dv_q_in   = '0;
            mb_acc_in = '0;
            mb_mc_in  = s_mag;
            mb_q_in   = eta;
            mb_cnt_in = smsc_pkg::ETA_CNT_W'(smsc_pkg::GAIN_W);
            cnt_in    = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            dv_rem_in = dv_rem_step;
            dv_q_in   = dv_q_step;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
               // smoothed sign ready: start k * sm on unit A
               ma_acc_in = '0;
               ma_mc_in  = kg_eff;
               ma_q_in   = QA_W'(dv_q_step);
               cnt_in    = '0;
               state_in  = ST_MUL2;
            end
         end
         ST_MUL2: begin
            // after FRAC_BITS steps the accumulator holds k*sm >> FRAC_BITS
            if (cnt_ff != CNT_W'(FRAC_BITS)) begin
               ma_acc_in = ma_sum[smsc_pkg::GAIN_W:1];
               ma_q_in   = {ma_sum[0], ma_q_ff[QA_W-1:1]};
               cnt_in    = cnt_ff + CNT_W'(1);
            end else if (mb_cnt_ff == '0) begin
               state_in = ST_DRIVE;
            end
         end
         ST_DRIVE: begin
            m_in     = smsc_pkg::M_W'(ma_acc_ff) + smsc_pkg::M_W'(b_sat);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output slot is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = s_neg_ff ? drive_mag : (smsc_pkg::DATA_W'(0) - drive_mag);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         mb_cnt_ff    <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mb_cnt_ff    <= mb_cnt_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      ma_acc_ff    <= ma_acc_in;
      ma_mc_ff     <= ma_mc_in;
      ma_q_ff      <= ma_q_in;
      x_ff         <= x_in;
      s_neg_ff     <= s_neg_in;
      dv_rem_ff    <= dv_rem_in;
      dv_den_ff    <= dv_den_in;
      dv_q_ff      <= dv_q_in;
      mb_acc_ff    <= mb_acc_in;
      mb_mc_ff     <= mb_mc_in;
      mb_q_ff      <= mb_q_in;
      m_ff         <= m_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // no transaction may start on a stale eta
   a_eta_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!ed_pend_ff && ed_cnt_ff == '0))
      else $error("transaction accepted while eta divide is busy");

   // integral never leaves the clamp window
   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      (SUM_W'(integ_ff) <= INTEG_MAX) && (SUM_W'(integ_ff) >= INTEG_MIN))
      else $error("error integral out of bounds");

   // restoring divider keeps its partial remainder below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dv_rem_ff < dv_den_ff))
      else $error("divider remainder not below divisor");

   // drive is formed only after the surface multiply has finished
   a_mulb_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRIVE) |-> (mb_cnt_ff == '0))
      else $error("drive formed before surface multiply finished");

endmodule
